@@ src/bilinear_crop_resize_assert.svh @@
// ----------------------------------------------------------------------------
// bilinear crop resize assertion macros
// shared property forms, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef BILINEAR_CROP_RESIZE_ASSERT_SVH
`define BILINEAR_CROP_RESIZE_ASSERT_SVH

// same-cycle implication
`define BCR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bcr assertion failed");

// next-cycle implication
`define BCR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bcr assertion failed");

`endif

@@ src/bcr_pkg.sv @@
// ----------------------------------------------------------------------------
// bcr_pkg
// shared types, codes and helpers of the bilinear crop resize block
// ----------------------------------------------------------------------------
package bcr_pkg;

  localparam int unsigned MAX_DIM          = 4096;
  localparam int unsigned STORE_PIXELS_DEF = 65536;
  localparam int unsigned HALF_Q16         = 32768;
  localparam int unsigned WEIGHT_ONE       = 256;

  localparam int unsigned DIM_W  = 13;
  localparam int unsigned POS_W  = 12;
  localparam int unsigned QUO_W  = 29;
  localparam int unsigned REM_W  = 12;
  localparam int unsigned NUM_W  = 28;
  localparam int unsigned CFG_IDX_W = 4;

  // input kinds
  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_EMIT  = 2'd1;
  localparam logic [1:0] MODE_START = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_W  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_H  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CROP_X   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CROP_Y   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CROP_W   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CROP_H   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_W    = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_H    = 4'd7;

  typedef struct packed {
    logic       load_we;
    logic       lp_clr;
    logic       div_start;
    logic       div_sel;     // 0 columns, 1 rows
    logic       tap_setup;
    logic       row_mul;
    logic       row_sel;
    logic       acc_clr;
    logic       tap_rd;
    logic [1:0] tap_idx;
    logic       advance;
    logic       out_load;
    logic       out_pix;
    logic       out_last;
    logic       out_status;
    logic       out_err;
  } dp_cmd_t;

  typedef struct packed {
    logic geo_ok;
    logic div_done;
    logic frame_last;
    logic out_busy;
  } dp_sts_t;

  typedef struct packed {
    logic [POS_W-1:0] i0;
    logic [POS_W-1:0] i1;
    logic [7:0]       frac;
  } taps_t;

  // split a walk position into two clamped tap indices and a q8 fraction
  function automatic taps_t tap_split(input logic [QUO_W-1:0] q,
                                      input logic [POS_W-1:0] origin,
                                      input logic [DIM_W-1:0] extent);
    logic [29:0] c;
    logic [13:0] fp1;
    logic [13:0] a;
    logic [13:0] b;
    logic [13:0] lo;
    logic [13:0] hi;
    taps_t       t;
    c   = {1'b0, q} + {2'b0, origin, 16'b0} + 30'(HALF_Q16);
    fp1 = c[29:16];
    a   = (fp1 == 14'd0) ? 14'd0 : fp1 - 14'd1;
    b   = fp1;
    lo  = {2'b0, origin};
    hi  = lo + {1'b0, extent} - 14'd1;
    if (a < lo) a = lo;
    if (a > hi) a = hi;
    if (b < lo) b = lo;
    if (b > hi) b = hi;
    t.i0   = a[POS_W-1:0];
    t.i1   = b[POS_W-1:0];
    t.frac = c[15:8];
    return t;
  endfunction

endpackage

@@ src/bcr_datapath.sv @@
// ----------------------------------------------------------------------------
// bcr_datapath
// registers, pixel store, seeding divider, source walks, blend and result
// ----------------------------------------------------------------------------
module bcr_datapath
  import bcr_pkg::*;
#(
  parameter int unsigned STORE_PIXELS = STORE_PIXELS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [DIM_W-1:0]     cfg_wdata,
  input  logic [23:0]          in_tdata,
  input  dp_cmd_t              cmd,
  output dp_sts_t              sts,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [23:0]          out_tdata,
  output logic                 out_tlast,
  output logic [1:0]           out_tuser
);

  localparam int unsigned ADDR_W = (STORE_PIXELS > 1) ? $clog2(STORE_PIXELS) : 1;
  localparam int unsigned LP_W   = $clog2(STORE_PIXELS + 1);
  localparam int unsigned DIV_STEPS = NUM_W;

  // configuration registers
  logic [DIM_W-1:0] fw_r, fh_r, cw_r, ch_r, ow_r, oh_r;
  logic [POS_W-1:0] cx_r, cy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= 13'd240; fh_r <= 13'd240; cx_r <= 12'd0; cy_r <= 12'd0;
      cw_r <= 13'd240; ch_r <= 13'd240; ow_r <= 13'd128; oh_r <= 13'd128;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_FRAME_W: fw_r <= cfg_wdata;
        REG_FRAME_H: fh_r <= cfg_wdata;
        REG_CROP_X:  cx_r <= cfg_wdata[POS_W-1:0];
        REG_CROP_Y:  cy_r <= cfg_wdata[POS_W-1:0];
        REG_CROP_W:  cw_r <= cfg_wdata;
        REG_CROP_H:  ch_r <= cfg_wdata;
        REG_OUT_W:   ow_r <= cfg_wdata;
        REG_OUT_H:   oh_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // geometry check
  logic [25:0] frame_px;
  logic [13:0] cx_end, cy_end;
  logic        dims_ok;
  assign frame_px = fw_r * fh_r;
  assign cx_end   = {2'b0, cx_r} + {1'b0, cw_r};
  assign cy_end   = {2'b0, cy_r} + {1'b0, ch_r};
  assign dims_ok  = (fw_r != '0) && (fh_r != '0) && (cw_r != '0) && (ch_r != '0) &&
                    (ow_r != '0) && (oh_r != '0) &&
                    (32'(fw_r) <= MAX_DIM) && (32'(fh_r) <= MAX_DIM) &&
                    (32'(cw_r) <= MAX_DIM) && (32'(ch_r) <= MAX_DIM) &&
                    (32'(ow_r) <= MAX_DIM) && (32'(oh_r) <= MAX_DIM);
  assign sts.geo_ok = dims_ok && (cx_end <= {1'b0, fw_r}) && (cy_end <= {1'b0, fh_r}) &&
                      (32'(frame_px) <= 32'(STORE_PIXELS));

  // load pointer
  logic [LP_W-1:0] lp_r;
  logic            load_do;
  assign load_do = cmd.load_we && (32'(lp_r) < 32'(frame_px)) &&
                   (32'(lp_r) < 32'(STORE_PIXELS));

  always_ff @(posedge clk) begin
    if (!rst_n) lp_r <= '0;
    else if (cmd.lp_clr) lp_r <= '0;
    else if (load_do) lp_r <= lp_r + LP_W'(1);
  end

  // seeding divider, restoring, one quotient bit a cycle
  logic             div_busy_r, div_done_r, div_sel_r;
  logic [4:0]       div_cnt_r;
  logic [NUM_W-1:0] div_num_r, div_quo_r;
  logic [REM_W-1:0] div_rem_r;
  logic [DIM_W-1:0] div_den_r;
  logic [DIM_W-1:0] div_trial;
  logic             div_ge;
  assign div_trial = {div_rem_r, div_num_r[NUM_W-1]};
  assign div_ge    = div_trial >= div_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
      div_done_r <= 1'b0;
      div_sel_r  <= 1'b0;
      div_cnt_r  <= '0;
    end else begin
      div_done_r <= div_busy_r && (div_cnt_r == 5'(DIV_STEPS - 1));
      if (cmd.div_start) begin
        div_busy_r <= 1'b1;
        div_sel_r  <= cmd.div_sel;
        div_cnt_r  <= '0;
      end else if (div_busy_r) begin
        div_cnt_r <= div_cnt_r + 5'd1;
        if (div_cnt_r == 5'(DIV_STEPS - 1)) div_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_num_r <= cmd.div_sel ? {ch_r, 15'b0} : {cw_r, 15'b0};
      div_den_r <= cmd.div_sel ? oh_r : ow_r;
      div_rem_r <= '0;
      div_quo_r <= '0;
    end else if (div_busy_r) begin
      div_num_r <= {div_num_r[NUM_W-2:0], 1'b0};
      div_rem_r <= div_ge ? REM_W'(div_trial - div_den_r) : div_trial[REM_W-1:0];
      div_quo_r <= {div_quo_r[NUM_W-2:0], div_ge};
    end
  end
  assign sts.div_done = div_done_r;

  // step from the seed: twice the seed numerator
  logic [DIM_W-1:0] rem2;
  logic             step_bit;
  logic [REM_W-1:0] step_rem;
  logic [QUO_W-1:0] step_quo;
  assign rem2     = {div_rem_r, 1'b0};
  assign step_bit = rem2 >= div_den_r;
  assign step_rem = step_bit ? REM_W'(rem2 - div_den_r) : rem2[REM_W-1:0];
  assign step_quo = {div_quo_r, step_bit};

  // source walks and output position
  logic [QUO_W-1:0] cseed_q_r, cstep_q_r, rstep_q_r, cwalk_q_r, rwalk_q_r;
  logic [REM_W-1:0] cseed_r_r, cstep_r_r, rstep_r_r, cwalk_r_r, rwalk_r_r;
  logic [POS_W-1:0] ocol_r;
  logic [DIM_W-1:0] orow_r;
  logic             col_last, row_last;
  logic [DIM_W:0]   csum, rsum;
  logic             cwrap, rwrap;

  assign col_last = ({1'b0, ocol_r} + 13'd1) >= ow_r;
  assign row_last = ({1'b0, orow_r} + 14'd1) >= {1'b0, oh_r};
  assign sts.frame_last = col_last && row_last;
  assign csum  = {2'b0, cwalk_r_r} + {2'b0, cstep_r_r};
  assign rsum  = {2'b0, rwalk_r_r} + {2'b0, rstep_r_r};
  assign cwrap = csum >= {1'b0, ow_r};
  assign rwrap = rsum >= {1'b0, oh_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cseed_q_r <= '0; cseed_r_r <= '0; cstep_q_r <= '0; cstep_r_r <= '0;
      rstep_q_r <= '0; rstep_r_r <= '0; cwalk_q_r <= '0; cwalk_r_r <= '0;
      rwalk_q_r <= '0; rwalk_r_r <= '0; ocol_r <= '0; orow_r <= '0;
    end else if (div_done_r) begin
      if (!div_sel_r) begin
        cseed_q_r <= {1'b0, div_quo_r};
        cseed_r_r <= div_rem_r;
        cstep_q_r <= step_quo;
        cstep_r_r <= step_rem;
      end else begin
        rwalk_q_r <= {1'b0, div_quo_r};
        rwalk_r_r <= div_rem_r;
        rstep_q_r <= step_quo;
        rstep_r_r <= step_rem;
        cwalk_q_r <= cseed_q_r;
        cwalk_r_r <= cseed_r_r;
        ocol_r    <= '0;
        orow_r    <= '0;
      end
    end else if (cmd.advance) begin
      if (!col_last) begin
        ocol_r    <= ocol_r + 12'd1;
        cwalk_q_r <= cwalk_q_r + cstep_q_r + QUO_W'(cwrap);
        cwalk_r_r <= cwrap ? REM_W'(csum - {1'b0, ow_r}) : csum[REM_W-1:0];
      end else begin
        ocol_r    <= '0;
        cwalk_q_r <= cseed_q_r;
        cwalk_r_r <= cseed_r_r;
        if (!row_last) begin
          orow_r    <= orow_r + 13'd1;
          rwalk_q_r <= rwalk_q_r + rstep_q_r + QUO_W'(rwrap);
          rwalk_r_r <= rwrap ? REM_W'(rsum - {1'b0, oh_r}) : rsum[REM_W-1:0];
        end
      end
    end
  end

  // tap coordinates and fractions
  taps_t            tx_r, ty_r;
  logic [23:0]      rowoff0_r, rowoff1_r;

  always_ff @(posedge clk) begin
    if (cmd.tap_setup) begin
      tx_r <= tap_split(cwalk_q_r, cx_r, cw_r);
      ty_r <= tap_split(rwalk_q_r, cy_r, ch_r);
    end
  end

  // row offsets, one multiplier shared by both tap rows
  logic [24:0] row_prod;
  assign row_prod = (cmd.row_sel ? ty_r.i1 : ty_r.i0) * fw_r;

  always_ff @(posedge clk) begin
    if (cmd.row_mul) begin
      if (cmd.row_sel) rowoff1_r <= row_prod[23:0];
      else             rowoff0_r <= row_prod[23:0];
    end
  end

  // tap address and weight
  logic [23:0] tap_addr;
  logic [8:0]  wx, wy;
  logic [17:0] w_prod;
  assign tap_addr = (cmd.tap_idx[1] ? rowoff1_r : rowoff0_r) +
                    {12'b0, (cmd.tap_idx[0] ? tx_r.i1 : tx_r.i0)};
  assign wx = cmd.tap_idx[0] ? {1'b0, tx_r.frac} : 9'(WEIGHT_ONE) - {1'b0, tx_r.frac};
  assign wy = cmd.tap_idx[1] ? {1'b0, ty_r.frac} : 9'(WEIGHT_ONE) - {1'b0, ty_r.frac};
  assign w_prod = wx * wy;

  // pixel store, single port
  logic [23:0] store [STORE_PIXELS];
  logic [23:0] rdata_r;
  logic [16:0] w_r;
  logic        rd_pend_r;

  always_ff @(posedge clk) begin
    if (load_do) store[lp_r[ADDR_W-1:0]] <= in_tdata;
    else if (cmd.tap_rd) rdata_r <= store[tap_addr[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) rd_pend_r <= 1'b0;
    else        rd_pend_r <= cmd.tap_rd;
  end

  always_ff @(posedge clk) begin
    if (cmd.tap_rd) w_r <= w_prod[16:0];
  end

  // blend accumulators, one lane per colour
  logic [24:0] acc_r [3];

  for (genvar g = 0; g < 3; g++) begin : g_lane
    always_ff @(posedge clk) begin
      if (cmd.acc_clr) acc_r[g] <= 25'(HALF_Q16);
      else if (rd_pend_r) acc_r[g] <= acc_r[g] + (rdata_r[g*8 +: 8] * w_r);
    end
  end

  // result register
  logic        ov_r, olast_r, ostat_r, oerr_r;
  logic [23:0] odata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (cmd.out_load) ov_r <= 1'b1;
    else if (out_tready) ov_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      olast_r <= cmd.out_last;
      ostat_r <= cmd.out_status;
      oerr_r  <= cmd.out_err;
      if (cmd.out_pix)
        // store order is blue low, result order is red low; minus 128 flips the msb
        odata_r <= {acc_r[0][23:16] ^ 8'h80, acc_r[1][23:16] ^ 8'h80,
                    acc_r[2][23:16] ^ 8'h80};
      else
        odata_r <= '0;
    end
  end

  assign sts.out_busy = ov_r;
  assign out_tvalid   = ov_r;
  assign out_tdata    = odata_r;
  assign out_tlast    = olast_r;
  assign out_tuser    = {oerr_r, ostat_r};

endmodule

@@ src/bcr_ctrl.sv @@
// ----------------------------------------------------------------------------
// bcr_ctrl
// sequencer for start, load and emit beats
// ----------------------------------------------------------------------------
module bcr_ctrl
  import bcr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [1:0]           in_tuser,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  dp_sts_t              sts,
  output dp_cmd_t              cmd
);

  `include "bilinear_crop_resize_assert.svh"

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DIV_COL = 4'd1;
  localparam logic [3:0] S_DIV_ROW = 4'd2;
  localparam logic [3:0] S_TAPS    = 4'd3;
  localparam logic [3:0] S_ROW0    = 4'd4;
  localparam logic [3:0] S_ROW1    = 4'd5;
  localparam logic [3:0] S_TAP     = 4'd6;
  localparam logic [3:0] S_DRAIN   = 4'd7;
  localparam logic [3:0] S_FIN     = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic [1:0] tap_r, tap_nxt;
  logic       ready_r, ready_nxt;
  logic       accept;

  assign in_tready = (state_r == S_IDLE) && !sts.out_busy;
  assign accept    = in_tvalid && in_tready;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    tap_nxt   = tap_r;
    ready_nxt = ready_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_tuser)
            MODE_LOAD: cmd.load_we = 1'b1;
            MODE_START: begin
              cmd.lp_clr = 1'b1;
              ready_nxt  = 1'b0;
              if (sts.geo_ok) begin
                cmd.div_start = 1'b1;
                state_nxt     = S_DIV_COL;
              end else begin
                cmd.out_load   = 1'b1;
                cmd.out_status = 1'b1;
                cmd.out_err    = 1'b1;
              end
            end
            MODE_EMIT: begin
              if (ready_r) begin
                state_nxt = S_TAPS;
              end else begin
                cmd.out_load = 1'b1;
                cmd.out_err  = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_DIV_COL: begin
        if (sts.div_done) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = 1'b1;
          state_nxt     = S_DIV_ROW;
        end
      end
      S_DIV_ROW: begin
        if (sts.div_done) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = 1'b1;
          ready_nxt      = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_TAPS: begin
        cmd.tap_setup = 1'b1;
        state_nxt     = S_ROW0;
      end
      S_ROW0: begin
        cmd.row_mul = 1'b1;
        cmd.acc_clr = 1'b1;
        state_nxt   = S_ROW1;
      end
      S_ROW1: begin
        cmd.row_mul = 1'b1;
        cmd.row_sel = 1'b1;
        tap_nxt     = 2'd0;
        state_nxt   = S_TAP;
      end
      S_TAP: begin
        cmd.tap_rd  = 1'b1;
        cmd.tap_idx = tap_r;
        tap_nxt     = tap_r + 2'd1;
        if (tap_r == 2'd3) state_nxt = S_DRAIN;
      end
      S_DRAIN: state_nxt = S_FIN;
      S_FIN: begin
        cmd.out_load = 1'b1;
        cmd.out_pix  = 1'b1;
        cmd.out_last = sts.frame_last;
        cmd.advance  = 1'b1;
        if (sts.frame_last) ready_nxt = 1'b0;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    // a write to a real register needs a fresh start
    if (cfg_we && (cfg_addr <= REG_OUT_H)) ready_nxt = 1'b0;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      tap_r   <= '0;
      ready_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tap_r   <= tap_nxt;
      ready_r <= ready_nxt;
    end
  end

  // checks
  `BCR_ASSERT_IMP(a_no_result_overrun, cmd.out_load, !sts.out_busy)
  `BCR_ASSERT_IMP(a_div_done_in_seed, sts.div_done, (state_r == S_DIV_COL) || (state_r == S_DIV_ROW))
  `BCR_ASSERT_NXT(a_last_ends_frame, cmd.advance && sts.frame_last, !ready_r)
  `BCR_ASSERT_IMP(a_emit_needs_frame, state_r == S_TAPS, ready_r)

endmodule

@@ src/bilinear_crop_resize.sv @@
// ----------------------------------------------------------------------------
// bilinear_crop_resize
// crop and bilinear resize of a bgr source frame into signed rgb samples
// ----------------------------------------------------------------------------
// in channel: tuser carries the beat kind (load, emit, start), tdata one bgr
// source pixel for a load. out channel: tdata the signed rgb pixel, tlast the
// final pixel of a frame, tuser the status and error flags.
// a load gives no beat. a start checks the geometry and runs two 28-step
// restoring divides on one shared divider before its status beat; a bad
// geometry gives an error status beat with no divide. an emit does tap
// setup, two row multiplies, the four tap reads through the single-port
// pixel store and the final blend before its beat. one beat is worked on
// at a time; the result sits in an output register and in_tready stays
// low until the receiver has taken it. reset (synchronous, rst_n low)
// restores the default geometry and leaves no frame started; the pixel
// store is not cleared, and the user must load every entry before it is
// read, which the block itself does not enforce. a write to a real
// register (index 0 to 7) ends the current frame.
// ----------------------------------------------------------------------------
module bilinear_crop_resize
  import bcr_pkg::*;
#(
  parameter int unsigned STORE_PIXELS = STORE_PIXELS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [DIM_W-1:0]     cfg_wdata,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [23:0]          in_tdata,   // blue, green, red
  input  logic [1:0]           in_tuser,   // mode
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [23:0]          out_tdata,  // red_out, green_out, blue_out
  output logic                 out_tlast,
  output logic [1:0]           out_tuser   // status_only, error
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer
  bcr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath and store
  bcr_datapath #(
    .STORE_PIXELS (STORE_PIXELS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// self-checking bench for bilinear_crop_resize: queue-fed stream driver,
// clocked monitor, and an independent scoreboard model of the geometry
// check, the half-pixel source walks and the q8 four-tap blend
// ----------------------------------------------------------------------------
module tb;
  import bcr_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd9;
  localparam int unsigned NUM_REGS = 8;
  localparam int unsigned STORE_SIZE = 65536;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [23:0] bgr;
  } src_beat_t;

  typedef struct packed {
    logic [23:0] rgb;
    logic        last;
    logic [1:0]  flags;
  } pix_beat_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [DIM_W-1:0]     cfg_wdata = '0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [23:0]          in_tdata = '0;   // blue, green, red
  logic [1:0]           in_tuser = '0;   // mode
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [23:0]          out_tdata;       // red_out, green_out, blue_out
  logic                 out_tlast;
  logic [1:0]           out_tuser;       // status_only, error

  bilinear_crop_resize dut (.*);

  always #6 clk = ~clk;

  // stimulus and expectations
  src_beat_t   beat_queue[$];
  pix_beat_t   pixel_queue[$];
  int unsigned fail_count = 0;
  int unsigned stall_cycles = 0;
  int unsigned idle_stage = 0;
  bit          beat_taken = 1'b0;

  // scoreboard model state
  logic [23:0] pix_mem [STORE_SIZE];
  int unsigned geo [NUM_REGS];
  int unsigned wr_ptr;
  int unsigned cseed_q, cseed_r, cstep_q, cstep_r, rstep_q, rstep_r;
  int unsigned cwalk_q, cwalk_r, rwalk_q, rwalk_r;
  int unsigned col_cnt, row_cnt;
  bit          frame_on;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    fail_count++;
  endtask

  function automatic bit geom_ok();
    bit ok;
    ok = 1'b1;
    for (int i = 0; i < NUM_REGS; i++)
      if (i != REG_CROP_X && i != REG_CROP_Y && (geo[i] == 0 || geo[i] > MAX_DIM)) ok = 1'b0;
    if (geo[REG_CROP_X] + geo[REG_CROP_W] > geo[REG_FRAME_W]) ok = 1'b0;
    if (geo[REG_CROP_Y] + geo[REG_CROP_H] > geo[REG_FRAME_H]) ok = 1'b0;
    if (geo[REG_FRAME_W] * geo[REG_FRAME_H] > STORE_SIZE) ok = 1'b0;
    return ok;
  endfunction

  // tap pair and q8 fraction from a walk quotient
  function automatic void tap_pos(input int unsigned q, input int unsigned org,
                                  input int unsigned ext, output int unsigned i0,
                                  output int unsigned i1, output int unsigned fr);
    longint unsigned c, whole, a, b, lo, hi;
    c = longint'(q) + (longint'(org) << 16) + 32768;
    whole = c >> 16;
    lo = org;
    hi = longint'(org) + ext - 1;
    a = (whole >= 1) ? whole - 1 : 0;
    b = whole;
    fr = 32'((c >> 8) & 64'hFF);
    if (a < lo) a = lo;
    if (a > hi) a = hi;
    if (b < lo) b = lo;
    if (b > hi) b = hi;
    i0 = 32'(a);
    i1 = 32'(b);
  endfunction

  function automatic logic [7:0] mix(input logic [7:0] s00, input logic [7:0] s01,
                                     input logic [7:0] s10, input logic [7:0] s11,
                                     input int unsigned fx, input int unsigned fy);
    int unsigned acc;
    acc = s00 * (256 - fx) * (256 - fy) + s01 * fx * (256 - fy) +
          s10 * (256 - fx) * fy + s11 * fx * fy + HALF_Q16;
    return 8'((acc >> 16) - 128);
  endfunction

  function automatic logic [23:0] fetch(input int unsigned idx);
    return (idx < STORE_SIZE) ? pix_mem[idx] : 24'd0;
  endfunction

  // work out the reply to one accepted source beat
  task automatic predict_pixel(input src_beat_t b);
    pix_beat_t   e;
    int unsigned x0, x1, y0, y1, fx, fy, n0, st;
    logic [23:0] p00, p01, p10, p11;
    e = '0;
    case (b.mode)
      MODE_LOAD: begin
        if (wr_ptr < geo[REG_FRAME_W] * geo[REG_FRAME_H] && wr_ptr < STORE_SIZE) begin
          pix_mem[wr_ptr] = b.bgr;
          wr_ptr++;
        end
        return;
      end
      MODE_START: begin
        wr_ptr = 0;
        e.flags[0] = 1'b1;
        if (!geom_ok()) begin
          frame_on = 1'b0;
          e.flags[1] = 1'b1;
        end else begin
          n0 = geo[REG_CROP_W] * HALF_Q16;
          st = 2 * n0;
          cseed_q = n0 / geo[REG_OUT_W];
          cseed_r = n0 % geo[REG_OUT_W];
          cstep_q = st / geo[REG_OUT_W];
          cstep_r = st % geo[REG_OUT_W];
          n0 = geo[REG_CROP_H] * HALF_Q16;
          st = 2 * n0;
          rwalk_q = n0 / geo[REG_OUT_H];
          rwalk_r = n0 % geo[REG_OUT_H];
          rstep_q = st / geo[REG_OUT_H];
          rstep_r = st % geo[REG_OUT_H];
          cwalk_q = cseed_q;
          cwalk_r = cseed_r;
          col_cnt = 0;
          row_cnt = 0;
          frame_on = 1'b1;
        end
      end
      MODE_EMIT: begin
        if (!frame_on) begin
          e.flags[1] = 1'b1;
        end else begin
          tap_pos(cwalk_q, geo[REG_CROP_X], geo[REG_CROP_W], x0, x1, fx);
          tap_pos(rwalk_q, geo[REG_CROP_Y], geo[REG_CROP_H], y0, y1, fy);
          p00 = fetch(y0 * geo[REG_FRAME_W] + x0);
          p01 = fetch(y0 * geo[REG_FRAME_W] + x1);
          p10 = fetch(y1 * geo[REG_FRAME_W] + x0);
          p11 = fetch(y1 * geo[REG_FRAME_W] + x1);
          for (int ch = 0; ch < 3; ch++)
            e.rgb[ch*8 +: 8] = mix(p00[(2-ch)*8 +: 8], p01[(2-ch)*8 +: 8],
                                   p10[(2-ch)*8 +: 8], p11[(2-ch)*8 +: 8], fx, fy);
          // step the column walk, wrapping to the next row at the edge
          if (col_cnt + 1 < geo[REG_OUT_W]) begin
            col_cnt++;
            cwalk_q += cstep_q;
            cwalk_r += cstep_r;
            if (cwalk_r >= geo[REG_OUT_W]) begin
              cwalk_r -= geo[REG_OUT_W];
              cwalk_q++;
            end
          end else begin
            col_cnt = 0;
            cwalk_q = cseed_q;
            cwalk_r = cseed_r;
            if (row_cnt + 1 < geo[REG_OUT_H]) begin
              row_cnt++;
              rwalk_q += rstep_q;
              rwalk_r += rstep_r;
              if (rwalk_r >= geo[REG_OUT_H]) begin
                rwalk_r -= geo[REG_OUT_H];
                rwalk_q++;
              end
            end else begin
              e.last = 1'b1;
              frame_on = 1'b0;
            end
          end
        end
      end
      default: return;
    endcase
    pixel_queue.push_back(e);
  endtask

  // monitor, scoreboard update and watchdog
  always @(posedge clk) begin
    pix_beat_t w;
    beat_taken = 1'b0;
    if (rst_n) begin
      stall_cycles++;
      if (out_tvalid && out_tready) begin
        stall_cycles = 0;
        if (pixel_queue.size() == 0) begin
          report("unexpected beat", {out_tuser, out_tlast, out_tdata}, 0);
        end else begin
          w = pixel_queue.pop_front();
          if (out_tdata !== w.rgb) report("rgb", out_tdata, w.rgb);
          if (out_tlast !== w.last) report("last", out_tlast, w.last);
          if (out_tuser !== w.flags) report("flags", out_tuser, w.flags);
        end
      end
      if (in_tvalid && in_tready) begin
        stall_cycles = 0;
        beat_taken = 1'b1;
        predict_pixel('{mode: in_tuser, bgr: in_tdata});
      end
      if (cfg_we) stall_cycles = 0;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  // source driver
  always @(negedge clk) begin
    src_beat_t nb;
    bit        hold;
    if (rst_n && (!in_tvalid || beat_taken)) begin
      hold = (idle_stage == 0 && $urandom_range(99) < 29) ||
             (idle_stage == 1 && $urandom_range(99) < 79);
      if (beat_queue.size() != 0 && !hold) begin
        nb = beat_queue.pop_front();
        in_tuser <= nb.mode;
        in_tdata <= nb.bgr;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    if (idle_stage == 0) out_tready <= ($urandom_range(99) >= 79);
    else if (idle_stage == 1) out_tready <= ($urandom_range(99) >= 29);
    else out_tready <= 1'b1;
  end

  task automatic drain();
    while (beat_queue.size() != 0 || in_tvalid || pixel_queue.size() != 0) @(negedge clk);
    // loads and spare beats give no reply, so allow the slowest job to finish
    repeat (80) @(negedge clk);
  endtask

  task automatic write_regs(input int unsigned v[NUM_REGS]);
    for (int i = 0; i < NUM_REGS; i++) begin
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_addr <= CFG_IDX_W'(i);
      cfg_wdata <= DIM_W'(v[i]);
      geo[i] = v[i] & ((i == REG_CROP_X || i == REG_CROP_Y) ? 32'hFFF : 32'h1FFF);
      frame_on = 1'b0;
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic src_beat_t mk(input logic [1:0] m);
    return '{mode: m, bgr: 24'($urandom)};
  endfunction

  // start, fill the whole frame, then walk every output pixel and one more
  task automatic run_frame(input int unsigned v[NUM_REGS], input bit noise);
    int unsigned pix;
    write_regs(v);
    beat_queue.push_back(mk(MODE_START));
    if (geom_ok()) begin
      pix = geo[REG_FRAME_W] * geo[REG_FRAME_H];
      for (int i = 0; i < pix + 2; i++) begin
        beat_queue.push_back(mk(MODE_LOAD));
        if (noise && $urandom_range(15) == 0) beat_queue.push_back(mk(MODE_SPARE));
      end
      for (int i = 0; i < geo[REG_OUT_W] * geo[REG_OUT_H] + 1; i++)
        beat_queue.push_back(mk(MODE_EMIT));
    end else if (noise) begin
      beat_queue.push_back(mk(MODE_EMIT));
    end
    drain();
  endtask

  initial begin
    int unsigned g[NUM_REGS];
    int unsigned fw, fh, cx, cy, frames;
    // reset
    for (int i = 0; i < NUM_REGS; i++) geo[i] = 0;
    geo[REG_FRAME_W] = 240; geo[REG_FRAME_H] = 240;
    geo[REG_CROP_W] = 240; geo[REG_CROP_H] = 240;
    geo[REG_OUT_W] = 128; geo[REG_OUT_H] = 128;
    wr_ptr = 0;
    frame_on = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // directed: emit with no frame, spare mode, start on reset geometry
    beat_queue.push_back(mk(MODE_EMIT));
    beat_queue.push_back(mk(MODE_SPARE));
    beat_queue.push_back(mk(MODE_START));
    beat_queue.push_back('{mode: MODE_LOAD, bgr: 24'hFFFFFF});
    drain();
    // bad geometries: zero, over range, crop off the frame, frame too big
    g = '{0, 4, 0, 0, 1, 1, 1, 1};          run_frame(g, 1);
    g = '{8191, 8191, 4095, 4095, 8191, 8191, 8191, 8191}; run_frame(g, 1);
    g = '{4, 4, 3, 0, 2, 4, 2, 2};          run_frame(g, 1);
    g = '{4096, 17, 0, 0, 4096, 17, 2, 2};  run_frame(g, 1);
    g = '{4, 4, 0, 0, 4, 4, 0, 3};          run_frame(g, 1);
    // extreme corners: 1x1 frame, and a 16-wide strip cropped to its last column
    g = '{1, 1, 0, 0, 1, 1, 3, 2};          run_frame(g, 0);
    g = '{16, 1, 15, 0, 1, 1, 16, 1};       run_frame(g, 0);
    g = '{2, 2, 0, 0, 2, 2, 4, 4};
    write_regs(g);
    beat_queue.push_back(mk(MODE_START));
    beat_queue.push_back('{mode: MODE_LOAD, bgr: 24'h000000});
    beat_queue.push_back('{mode: MODE_LOAD, bgr: 24'hFFFFFF});
    beat_queue.push_back('{mode: MODE_LOAD, bgr: 24'hFF00FF});
    beat_queue.push_back('{mode: MODE_LOAD, bgr: 24'h00FF00});
    drain();
    // unused register index leaves the frame running
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= REG_UNUSED;
    cfg_wdata <= '1;
    @(negedge clk);
    cfg_we <= 1'b0;
    for (int i = 0; i < 17; i++) beat_queue.push_back(mk(MODE_EMIT));
    drain();

    // random frames, mostly well formed, in three back-pressure stages
    frames = 0;
    for (int stg = 0; stg < 3; stg++) begin
      idle_stage = stg;
      for (int k = 0; k < 4; k++) begin
        fw = $urandom_range(8, 1);
        fh = $urandom_range(6, 1);
        cx = $urandom_range(fw - 1);
        cy = $urandom_range(fh - 1);
        g = '{fw, fh, cx, cy, $urandom_range(fw - cx, 1), $urandom_range(fh - cy, 1),
              $urandom_range(7, 1), $urandom_range(5, 1)};
        // occasional zero or over-range register
        if ($urandom_range(7) == 0)
          g[$urandom_range(NUM_REGS - 1)] = $urandom_range(1) ? 0 : $urandom_range(8191, 4097);
        run_frame(g, 1);
        frames++;
      end
    end

    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
